// ===== sv/fjov_pkg.sv =====
package fjov_pkg;

  // Entries in the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Object-level parse phase
  typedef enum logic [3:0] {
    PH_OPEN     = 4'd0,
    PH_TOP      = 4'd1,
    PH_KEYWAIT  = 4'd2,
    PH_KEY      = 4'd3,
    PH_COLON    = 4'd4,
    PH_VALWAIT  = 4'd5,
    PH_STR      = 4'd6,
    PH_NUM      = 4'd7,
    PH_AFTERVAL = 4'd8,
    PH_END      = 4'd9,
    PH_ERR      = 4'd10,
    PH_COMMA    = 4'd11
  } phase_t;

  // Number grammar phase
  typedef enum logic [4:0] {
    NS_START    = 5'd0,
    NS_SIGN     = 5'd1,
    NS_ZERO     = 5'd2,
    NS_INT      = 5'd3,
    NS_DOT0     = 5'd4,
    NS_FRAC     = 5'd5,
    NS_E        = 5'd6,
    NS_ESIGN    = 5'd7,
    NS_EXP      = 5'd8,
    NS_HX       = 5'd9,
    NS_HINT     = 5'd10,
    NS_HDOT0    = 5'd11,
    NS_HFRAC    = 5'd12,
    NS_P        = 5'd13,
    NS_PSIGN    = 5'd14,
    NS_PEXP     = 5'd15,
    NS_I        = 5'd16,
    NS_IN       = 5'd17,
    NS_INF      = 5'd18,
    NS_INFI     = 5'd19,
    NS_INFIN    = 5'd20,
    NS_INFINI   = 5'd21,
    NS_INFINIT  = 5'd22,
    NS_INFINITY = 5'd23,
    NS_N        = 5'd24,
    NS_NA       = 5'd25,
    NS_NAN      = 5'd26,
    NS_NANP     = 5'd27,
    NS_NANDONE  = 5'd28,
    NS_STOP     = 5'd31
  } num_phase_t;

  // Structural token of a byte
  typedef enum logic [3:0] {
    TK_OTHER  = 4'd0,
    TK_ZERO   = 4'd1,
    TK_LBRACE = 4'd2,
    TK_RBRACE = 4'd3,
    TK_QUOTE  = 4'd4,
    TK_COLON  = 4'd5,
    TK_COMMA  = 4'd6,
    TK_SPACE  = 4'd7,
    TK_DOT    = 4'd8,
    TK_LPAREN = 4'd9,
    TK_RPAREN = 4'd10,
    TK_SIGN   = 4'd11
  } token_t;

  // Byte class reported with each result
  typedef enum logic [2:0] {
    CLS_STRUCT  = 3'd0,
    CLS_KEY     = 3'd1,
    CLS_STR     = 3'd2,
    CLS_NUM     = 3'd3,
    CLS_IGNORED = 3'd4
  } byte_class_t;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_EMPTY     = 4'd1,
    ERR_NO_BRACE  = 4'd2,
    ERR_BAD_END   = 4'd3,
    ERR_KEY       = 4'd4,
    ERR_KEY_QUOTE = 4'd5,
    ERR_COLON     = 4'd6,
    ERR_VALUE     = 4'd7,
    ERR_STR_QUOTE = 4'd8,
    ERR_NUMBER    = 4'd9,
    ERR_COMMA     = 4'd10
  } err_t;

  // Classified byte passed from front to back
  typedef struct packed {
    token_t     tok;
    logic [7:0] lc;       // lower-cased byte
    logic       is_ws;    // space or tab..CR
    logic       is_dig;
    logic       is_hex;
    logic       is_alnum; // letter, digit or underscore
  } char_info_t;

endpackage

// ===== sv/fjov_text_if.sv =====
interface fjov_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ===== sv/fjov_result_if.sv =====
interface fjov_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_class;
  logic       key_end;
  logic       value_end;
  logic       text_done;
  logic       accepted;
  logic [3:0] error_kind;

  modport source (
    output valid, output byte_class, output key_end, output value_end,
    output text_done, output accepted, output error_kind, input ready
  );
  modport sink (
    input valid, input byte_class, input key_end, input value_end,
    input text_done, input accepted, input error_kind, output ready
  );
endinterface

// ===== sv/fjov_front.sv =====
module fjov_front (
  input  logic                 clk,
  input  logic                 rst,
  fjov_text_if.sink            text,
  output fjov_pkg::char_info_t info,
  output logic                 info_valid,
  input  logic                 info_ready
);

  fjov_pkg::char_info_t cls;
  logic [7:0]           c;
  logic                 dig;

  // Byte classification
  always_comb begin
    c   = text.text_byte;
    dig = c inside {["0":"9"]};
    cls.lc = (c inside {["A":"Z"]}) ? c + 8'd32 : c;
    case (c)
      8'h00:   cls.tok = fjov_pkg::TK_ZERO;
      "{":     cls.tok = fjov_pkg::TK_LBRACE;
      "}":     cls.tok = fjov_pkg::TK_RBRACE;
      8'h22:   cls.tok = fjov_pkg::TK_QUOTE;
      ":":     cls.tok = fjov_pkg::TK_COLON;
      ",":     cls.tok = fjov_pkg::TK_COMMA;
      " ":     cls.tok = fjov_pkg::TK_SPACE;
      ".":     cls.tok = fjov_pkg::TK_DOT;
      "(":     cls.tok = fjov_pkg::TK_LPAREN;
      ")":     cls.tok = fjov_pkg::TK_RPAREN;
      "+", "-": cls.tok = fjov_pkg::TK_SIGN;
      default: cls.tok = fjov_pkg::TK_OTHER;
    endcase
    cls.is_ws    = (c == " ") || (c inside {[8'd9:8'd13]});
    cls.is_dig   = dig;
    cls.is_hex   = dig || (cls.lc inside {["a":"f"]});
    cls.is_alnum = dig || (cls.lc inside {["a":"z"]}) || (c == "_");
  end

  // One-entry output stage
  assign text.ready = !info_valid || info_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      info_valid <= 1'b0;
    end else if (text.ready) begin
      info_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      info <= cls;
    end
  end

endmodule

// ===== sv/fjov_queue.sv =====
module fjov_queue #(
  parameter int Depth = fjov_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fjov_pkg::char_info_t push_data,
  input  logic                 push_valid,
  output logic                 push_ready,
  output fjov_pkg::char_info_t pop_data,
  output logic                 pop_valid,
  input  logic                 pop_ready
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fjov_pkg::char_info_t entries [Depth];
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CntW-1:0]      count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/fjov_back.sv =====
module fjov_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fjov_pkg::char_info_t info,
  input  logic                 info_valid,
  output logic                 info_ready,
  fjov_result_if.source        result
);

  // Number grammar step
  function automatic fjov_pkg::num_phase_t num_next(fjov_pkg::num_phase_t s,
                                                    fjov_pkg::char_info_t ch);
    fjov_pkg::num_phase_t r;
    logic                 sg;
    logic                 dot;
    sg  = (ch.tok == fjov_pkg::TK_SIGN);
    dot = (ch.tok == fjov_pkg::TK_DOT);
    r   = fjov_pkg::NS_STOP;
    case (s)
      fjov_pkg::NS_START, fjov_pkg::NS_SIGN: begin
        if (s == fjov_pkg::NS_START && ch.is_ws) r = fjov_pkg::NS_START;
        else if (s == fjov_pkg::NS_START && sg) r = fjov_pkg::NS_SIGN;
        else if (ch.lc == "0") r = fjov_pkg::NS_ZERO;
        else if (ch.is_dig) r = fjov_pkg::NS_INT;
        else if (dot) r = fjov_pkg::NS_DOT0;
        else if (ch.lc == "i") r = fjov_pkg::NS_I;
        else if (ch.lc == "n") r = fjov_pkg::NS_N;
      end
      fjov_pkg::NS_ZERO, fjov_pkg::NS_INT: begin
        if (s == fjov_pkg::NS_ZERO && ch.lc == "x") r = fjov_pkg::NS_HX;
        else if (ch.is_dig) r = fjov_pkg::NS_INT;
        else if (dot) r = fjov_pkg::NS_FRAC;
        else if (ch.lc == "e") r = fjov_pkg::NS_E;
      end
      fjov_pkg::NS_DOT0: if (ch.is_dig) r = fjov_pkg::NS_FRAC;
      fjov_pkg::NS_FRAC: begin
        if (ch.is_dig) r = fjov_pkg::NS_FRAC;
        else if (ch.lc == "e") r = fjov_pkg::NS_E;
      end
      fjov_pkg::NS_E: begin
        if (sg) r = fjov_pkg::NS_ESIGN;
        else if (ch.is_dig) r = fjov_pkg::NS_EXP;
      end
      fjov_pkg::NS_ESIGN, fjov_pkg::NS_EXP: if (ch.is_dig) r = fjov_pkg::NS_EXP;
      fjov_pkg::NS_HX: begin
        if (ch.is_hex) r = fjov_pkg::NS_HINT;
        else if (dot) r = fjov_pkg::NS_HDOT0;
      end
      fjov_pkg::NS_HINT: begin
        if (ch.is_hex) r = fjov_pkg::NS_HINT;
        else if (dot) r = fjov_pkg::NS_HFRAC;
        else if (ch.lc == "p") r = fjov_pkg::NS_P;
      end
      fjov_pkg::NS_HDOT0: if (ch.is_hex) r = fjov_pkg::NS_HFRAC;
      fjov_pkg::NS_HFRAC: begin
        if (ch.is_hex) r = fjov_pkg::NS_HFRAC;
        else if (ch.lc == "p") r = fjov_pkg::NS_P;
      end
      fjov_pkg::NS_P: begin
        if (sg) r = fjov_pkg::NS_PSIGN;
        else if (ch.is_dig) r = fjov_pkg::NS_PEXP;
      end
      fjov_pkg::NS_PSIGN, fjov_pkg::NS_PEXP: if (ch.is_dig) r = fjov_pkg::NS_PEXP;
      fjov_pkg::NS_I:       if (ch.lc == "n") r = fjov_pkg::NS_IN;
      fjov_pkg::NS_IN:      if (ch.lc == "f") r = fjov_pkg::NS_INF;
      fjov_pkg::NS_INF:     if (ch.lc == "i") r = fjov_pkg::NS_INFI;
      fjov_pkg::NS_INFI:    if (ch.lc == "n") r = fjov_pkg::NS_INFIN;
      fjov_pkg::NS_INFIN:   if (ch.lc == "i") r = fjov_pkg::NS_INFINI;
      fjov_pkg::NS_INFINI:  if (ch.lc == "t") r = fjov_pkg::NS_INFINIT;
      fjov_pkg::NS_INFINIT: if (ch.lc == "y") r = fjov_pkg::NS_INFINITY;
      fjov_pkg::NS_N:       if (ch.lc == "a") r = fjov_pkg::NS_NA;
      fjov_pkg::NS_NA:      if (ch.lc == "n") r = fjov_pkg::NS_NAN;
      fjov_pkg::NS_NAN:     if (ch.tok == fjov_pkg::TK_LPAREN) r = fjov_pkg::NS_NANP;
      fjov_pkg::NS_NANP: begin
        if (ch.tok == fjov_pkg::TK_RPAREN) r = fjov_pkg::NS_NANDONE;
        else if (ch.is_alnum) r = fjov_pkg::NS_NANP;
      end
      default: r = fjov_pkg::NS_STOP;
    endcase
    return r;
  endfunction

  // Phases at which a complete number has been seen
  function automatic logic num_matched(fjov_pkg::num_phase_t s);
    return s inside {fjov_pkg::NS_ZERO, fjov_pkg::NS_INT, fjov_pkg::NS_FRAC,
                     fjov_pkg::NS_EXP, fjov_pkg::NS_HINT, fjov_pkg::NS_HFRAC,
                     fjov_pkg::NS_PEXP, fjov_pkg::NS_INF, fjov_pkg::NS_INFINITY,
                     fjov_pkg::NS_NAN, fjov_pkg::NS_NANDONE};
  endfunction

  fjov_pkg::phase_t      parse_phase, parse_phase_next;
  fjov_pkg::num_phase_t  number_phase, number_phase_next;
  logic                  prefix_matched, prefix_matched_next;
  fjov_pkg::err_t        first_error, first_error_next;

  fjov_pkg::byte_class_t cls;
  logic                  ke, ve, done, acc;
  fjov_pkg::err_t        ek;

  fjov_pkg::num_phase_t  ns_cur, nx;
  logic                  pm_cur;
  logic                  av_ok;
  fjov_pkg::phase_t      av_phase;
  logic                  do_fail;
  fjov_pkg::err_t        fail_kind;

  logic                  rv;
  logic                  pop;

  assign pop        = info_valid && (!rv || result.ready);
  assign info_ready = !rv || result.ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= fjov_pkg::PH_OPEN;
      number_phase   <= fjov_pkg::NS_START;
      prefix_matched <= 1'b0;
      first_error    <= fjov_pkg::ERR_NONE;
    end else if (pop) begin
      parse_phase    <= parse_phase_next;
      number_phase   <= number_phase_next;
      prefix_matched <= prefix_matched_next;
      first_error    <= first_error_next;
    end
  end

  // Next state and result fields for the byte at the head of the queue
  always_comb begin
    parse_phase_next    = parse_phase;
    number_phase_next   = number_phase;
    prefix_matched_next = prefix_matched;
    first_error_next    = first_error;
    cls       = fjov_pkg::CLS_STRUCT;
    ke        = 1'b0;
    ve        = 1'b0;
    done      = 1'b0;
    acc       = 1'b0;
    ek        = fjov_pkg::ERR_NONE;
    do_fail   = 1'b0;
    fail_kind = fjov_pkg::ERR_NONE;

    // a number starts fresh from the value-wait phase
    ns_cur = (parse_phase == fjov_pkg::PH_VALWAIT) ? fjov_pkg::NS_START : number_phase;
    pm_cur = (parse_phase == fjov_pkg::PH_VALWAIT) ? 1'b0 : prefix_matched;
    nx     = num_next(ns_cur, info);

    // separator after a value
    av_ok    = 1'b1;
    av_phase = fjov_pkg::PH_ERR;
    case (info.tok)
      fjov_pkg::TK_SPACE:  av_phase = fjov_pkg::PH_AFTERVAL;
      fjov_pkg::TK_COMMA:  av_phase = fjov_pkg::PH_COMMA;
      fjov_pkg::TK_RBRACE: av_phase = fjov_pkg::PH_END;
      default:             av_ok = 1'b0;
    endcase

    case (parse_phase)
      fjov_pkg::PH_OPEN: begin
        if (info.tok == fjov_pkg::TK_ZERO) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_EMPTY;
        end else if (info.tok == fjov_pkg::TK_LBRACE) begin
          parse_phase_next = fjov_pkg::PH_TOP;
        end else begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_NO_BRACE;
        end
      end
      fjov_pkg::PH_TOP, fjov_pkg::PH_COMMA: begin
        if (info.tok == fjov_pkg::TK_RBRACE) begin
          parse_phase_next = fjov_pkg::PH_END;
        end else if (info.tok == fjov_pkg::TK_ZERO) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_BAD_END;
        end else if (info.tok == fjov_pkg::TK_QUOTE) begin
          parse_phase_next = fjov_pkg::PH_KEY;
          cls = fjov_pkg::CLS_KEY;
        end else if (info.tok == fjov_pkg::TK_SPACE) begin
          // spaces after a comma keep the comma phase
          if (parse_phase == fjov_pkg::PH_TOP) parse_phase_next = fjov_pkg::PH_KEYWAIT;
        end else begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_KEY;
        end
      end
      fjov_pkg::PH_KEYWAIT: begin
        if (info.tok == fjov_pkg::TK_QUOTE) begin
          parse_phase_next = fjov_pkg::PH_KEY;
          cls = fjov_pkg::CLS_KEY;
        end else if (info.tok != fjov_pkg::TK_SPACE) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_KEY;
        end
      end
      fjov_pkg::PH_KEY: begin
        if (info.tok == fjov_pkg::TK_ZERO) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_KEY_QUOTE;
        end else begin
          cls = fjov_pkg::CLS_KEY;
          if (info.tok == fjov_pkg::TK_QUOTE) begin
            ke = 1'b1;
            parse_phase_next = fjov_pkg::PH_COLON;
          end
        end
      end
      fjov_pkg::PH_COLON: begin
        if (info.tok == fjov_pkg::TK_COLON) begin
          parse_phase_next = fjov_pkg::PH_VALWAIT;
        end else if (info.tok != fjov_pkg::TK_SPACE) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_COLON;
        end
      end
      fjov_pkg::PH_VALWAIT, fjov_pkg::PH_NUM: begin
        if (parse_phase == fjov_pkg::PH_VALWAIT && info.tok == fjov_pkg::TK_SPACE) begin
          // skip
        end else if (parse_phase == fjov_pkg::PH_VALWAIT &&
                     (info.tok == fjov_pkg::TK_ZERO || info.tok == fjov_pkg::TK_RBRACE)) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_VALUE;
        end else if (parse_phase == fjov_pkg::PH_VALWAIT &&
                     info.tok == fjov_pkg::TK_QUOTE) begin
          parse_phase_next = fjov_pkg::PH_STR;
          cls = fjov_pkg::CLS_STR;
        end else begin
          // number byte
          parse_phase_next    = fjov_pkg::PH_NUM;
          number_phase_next   = ns_cur;
          prefix_matched_next = pm_cur;
          if (nx != fjov_pkg::NS_STOP) begin
            number_phase_next = nx;
            if (num_matched(nx)) prefix_matched_next = 1'b1;
            cls = (nx == fjov_pkg::NS_START) ? fjov_pkg::CLS_STRUCT : fjov_pkg::CLS_NUM;
          end else if (num_matched(ns_cur)) begin
            if (av_ok) begin
              parse_phase_next = av_phase;
              ve = 1'b1;
            end else begin
              do_fail = 1'b1; fail_kind = fjov_pkg::ERR_COMMA;
            end
          end else begin
            do_fail   = 1'b1;
            fail_kind = pm_cur ? fjov_pkg::ERR_COMMA : fjov_pkg::ERR_NUMBER;
          end
        end
      end
      fjov_pkg::PH_STR: begin
        if (info.tok == fjov_pkg::TK_ZERO) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_STR_QUOTE;
        end else begin
          cls = fjov_pkg::CLS_STR;
          if (info.tok == fjov_pkg::TK_QUOTE) begin
            ve = 1'b1;
            parse_phase_next = fjov_pkg::PH_AFTERVAL;
          end
        end
      end
      fjov_pkg::PH_AFTERVAL: begin
        if (av_ok) begin
          parse_phase_next = av_phase;
        end else begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_COMMA;
        end
      end
      fjov_pkg::PH_END: begin
        if (info.tok != fjov_pkg::TK_ZERO) begin
          do_fail = 1'b1; fail_kind = fjov_pkg::ERR_BAD_END;
        end
      end
      fjov_pkg::PH_ERR: cls = fjov_pkg::CLS_IGNORED;
      default: begin
        do_fail = 1'b1; fail_kind = fjov_pkg::ERR_BAD_END;
      end
    endcase

    // keep only the first error
    if (do_fail) begin
      if (first_error == fjov_pkg::ERR_NONE) first_error_next = fail_kind;
      parse_phase_next = fjov_pkg::PH_ERR;
      cls = fjov_pkg::CLS_IGNORED;
    end

    // end of text: report and start over
    if (info.tok == fjov_pkg::TK_ZERO) begin
      done = 1'b1;
      cls  = fjov_pkg::CLS_STRUCT;
      ek   = first_error_next;
      acc  = (first_error_next == fjov_pkg::ERR_NONE);
      parse_phase_next    = fjov_pkg::PH_OPEN;
      number_phase_next   = fjov_pkg::NS_START;
      prefix_matched_next = 1'b0;
      first_error_next    = fjov_pkg::ERR_NONE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (!rv || result.ready) begin
      rv <= info_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.byte_class <= cls;
      result.key_end    <= ke;
      result.value_end  <= ve;
      result.text_done  <= done;
      result.accepted   <= acc;
      result.error_kind <= ek;
    end
  end

  assign result.valid = rv;

endmodule

// ===== sv/flat_json_object_validator.sv =====
// Flat JSON object validator.
// Channel text carries one byte per transfer (text_byte); a zero byte ends
// the text. Channel result returns exactly one item per byte: its class
// (structure/space, key, string value, number, ignored after an error),
// key and value end marks, and on the zero byte text_done with accepted
// and the first error code. After the zero byte a new text may follow.
// Throughput: one byte per cycle while the receiver holds ready high; the
// back end updates its parse state once per byte. A byte passes through
// the classify register, a queue entry and the output register before
// its result is valid.
// Reset (rst, synchronous, active high) empties all stages and puts the
// parser at the start of a text with no error recorded.
// When the receiver holds ready low, the output register holds its item,
// the queue fills up and then text.ready drops; no item is lost or
// repeated, and transfers resume at full rate once ready returns.
module flat_json_object_validator #(
  parameter int QueueDepth = fjov_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  fjov_text_if.sink     text,
  fjov_result_if.source result
);

  fjov_pkg::char_info_t front_info;
  logic                 front_valid;
  logic                 front_ready;
  fjov_pkg::char_info_t back_info;
  logic                 back_valid;
  logic                 back_ready;

  // Byte classifier
  fjov_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .info       (front_info),
    .info_valid (front_valid),
    .info_ready (front_ready)
  );

  // Decoupling queue
  fjov_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_info),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_info),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Parser and result register
  fjov_back u_back (
    .clk        (clk),
    .rst        (rst),
    .info       (back_info),
    .info_valid (back_valid),
    .info_ready (back_ready),
    .result     (result)
  );

endmodule

// ===== sv/fjov_checker.sv =====
module fjov_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [2:0] byte_class,
  input logic       key_end,
  input logic       value_end,
  input logic       text_done,
  input logic       accepted,
  input logic [3:0] error_kind
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(byte_class) && $stable(text_done) &&
    $stable(error_kind) && $stable(accepted))
    else $error("stalled result changed");

  // Verdict agrees with the error code at end of text
  assert property (@(posedge clk) disable iff (rst)
    valid && text_done |-> (accepted == (error_kind == fjov_pkg::ERR_NONE)))
    else $error("accepted does not match error_kind");

  // Verdict only on the end byte
  assert property (@(posedge clk) disable iff (rst)
    valid && !text_done |-> !accepted && error_kind == fjov_pkg::ERR_NONE)
    else $error("verdict outside end of text");

  // End byte is plain structure with no end marks
  assert property (@(posedge clk) disable iff (rst)
    valid && text_done |-> byte_class == fjov_pkg::CLS_STRUCT && !key_end && !value_end)
    else $error("end byte classified wrongly");

  // Key and value ends never coincide, class stays in range
  assert property (@(posedge clk) disable iff (rst)
    valid |-> !(key_end && value_end) && byte_class <= fjov_pkg::CLS_IGNORED)
    else $error("bad class or end marks");

endmodule

bind flat_json_object_validator fjov_checker u_fjov_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (result.valid),
  .ready      (result.ready),
  .byte_class (result.byte_class),
  .key_end    (result.key_end),
  .value_end  (result.value_end),
  .text_done  (result.text_done),
  .accepted   (result.accepted),
  .error_kind (result.error_kind)
);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Tag that the block returns for every byte
  typedef struct {
    fjov_pkg::byte_class_t cls;
    logic                  key_end;
    logic                  value_end;
    logic                  text_done;
    logic                  accepted;
    fjov_pkg::err_t        err;
  } byte_tag_t;

  // Parser model plus the queue of tags still owed by the block
  class json_tag_board;
    fjov_pkg::phase_t     phase;
    fjov_pkg::num_phase_t num_st;
    logic                 got_prefix;
    fjov_pkg::err_t       first_err;
    byte_tag_t            expected_tags[$];
    int                   failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase      = fjov_pkg::PH_OPEN;
      num_st     = fjov_pkg::NS_START;
      got_prefix = 1'b0;
      first_err  = fjov_pkg::ERR_NONE;
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function bit is_hexdig(logic [7:0] c);
      return is_digit(c) || (lower(c) >= "a" && lower(c) <= "f");
    endfunction

    function bit is_word(logic [7:0] c);
      return is_digit(c) || (lower(c) >= "a" && lower(c) <= "z") || c == "_";
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit num_accepting(fjov_pkg::num_phase_t s);
      return s inside {fjov_pkg::NS_ZERO, fjov_pkg::NS_INT, fjov_pkg::NS_FRAC,
                       fjov_pkg::NS_EXP, fjov_pkg::NS_HINT, fjov_pkg::NS_HFRAC,
                       fjov_pkg::NS_PEXP, fjov_pkg::NS_INF, fjov_pkg::NS_INFINITY,
                       fjov_pkg::NS_NAN, fjov_pkg::NS_NANDONE};
    endfunction

    // Next phase of the strtod grammar, NS_STOP when the byte does not extend it
    function fjov_pkg::num_phase_t num_advance(fjov_pkg::num_phase_t s, logic [7:0] c);
      logic [7:0] l;
      bit         sg;
      l  = lower(c);
      sg = (c == "+" || c == "-");
      case (s)
        fjov_pkg::NS_START, fjov_pkg::NS_SIGN: begin
          if (s == fjov_pkg::NS_START && is_blank(c)) return fjov_pkg::NS_START;
          if (s == fjov_pkg::NS_START && sg) return fjov_pkg::NS_SIGN;
          if (c == "0") return fjov_pkg::NS_ZERO;
          if (is_digit(c)) return fjov_pkg::NS_INT;
          if (c == ".") return fjov_pkg::NS_DOT0;
          if (l == "i") return fjov_pkg::NS_I;
          if (l == "n") return fjov_pkg::NS_N;
        end
        fjov_pkg::NS_ZERO, fjov_pkg::NS_INT: begin
          if (s == fjov_pkg::NS_ZERO && l == "x") return fjov_pkg::NS_HX;
          if (is_digit(c)) return fjov_pkg::NS_INT;
          if (c == ".") return fjov_pkg::NS_FRAC;
          if (l == "e") return fjov_pkg::NS_E;
        end
        fjov_pkg::NS_DOT0:  if (is_digit(c)) return fjov_pkg::NS_FRAC;
        fjov_pkg::NS_FRAC: begin
          if (is_digit(c)) return fjov_pkg::NS_FRAC;
          if (l == "e") return fjov_pkg::NS_E;
        end
        fjov_pkg::NS_E: begin
          if (sg) return fjov_pkg::NS_ESIGN;
          if (is_digit(c)) return fjov_pkg::NS_EXP;
        end
        fjov_pkg::NS_ESIGN, fjov_pkg::NS_EXP: if (is_digit(c)) return fjov_pkg::NS_EXP;
        fjov_pkg::NS_HX: begin
          if (is_hexdig(c)) return fjov_pkg::NS_HINT;
          if (c == ".") return fjov_pkg::NS_HDOT0;
        end
        fjov_pkg::NS_HINT: begin
          if (is_hexdig(c)) return fjov_pkg::NS_HINT;
          if (c == ".") return fjov_pkg::NS_HFRAC;
          if (l == "p") return fjov_pkg::NS_P;
        end
        fjov_pkg::NS_HDOT0: if (is_hexdig(c)) return fjov_pkg::NS_HFRAC;
        fjov_pkg::NS_HFRAC: begin
          if (is_hexdig(c)) return fjov_pkg::NS_HFRAC;
          if (l == "p") return fjov_pkg::NS_P;
        end
        fjov_pkg::NS_P: begin
          if (sg) return fjov_pkg::NS_PSIGN;
          if (is_digit(c)) return fjov_pkg::NS_PEXP;
        end
        fjov_pkg::NS_PSIGN, fjov_pkg::NS_PEXP: if (is_digit(c)) return fjov_pkg::NS_PEXP;
        fjov_pkg::NS_I:       if (l == "n") return fjov_pkg::NS_IN;
        fjov_pkg::NS_IN:      if (l == "f") return fjov_pkg::NS_INF;
        fjov_pkg::NS_INF:     if (l == "i") return fjov_pkg::NS_INFI;
        fjov_pkg::NS_INFI:    if (l == "n") return fjov_pkg::NS_INFIN;
        fjov_pkg::NS_INFIN:   if (l == "i") return fjov_pkg::NS_INFINI;
        fjov_pkg::NS_INFINI:  if (l == "t") return fjov_pkg::NS_INFINIT;
        fjov_pkg::NS_INFINIT: if (l == "y") return fjov_pkg::NS_INFINITY;
        fjov_pkg::NS_N:       if (l == "a") return fjov_pkg::NS_NA;
        fjov_pkg::NS_NA:      if (l == "n") return fjov_pkg::NS_NAN;
        fjov_pkg::NS_NAN:     if (c == "(") return fjov_pkg::NS_NANP;
        fjov_pkg::NS_NANP: begin
          if (c == ")") return fjov_pkg::NS_NANDONE;
          if (is_word(c)) return fjov_pkg::NS_NANP;
        end
        default: ;
      endcase
      return fjov_pkg::NS_STOP;
    endfunction

    // Records the error (first one wins) and parks the parser
    function fjov_pkg::byte_class_t raise(fjov_pkg::err_t kind);
      if (first_err == fjov_pkg::ERR_NONE) first_err = kind;
      phase = fjov_pkg::PH_ERR;
      return fjov_pkg::CLS_IGNORED;
    endfunction

    // Byte right after a value: space, comma or closing brace
    function bit close_value(logic [7:0] c);
      if (c == CH_SPACE) phase = fjov_pkg::PH_AFTERVAL;
      else if (c == CH_COMMA) phase = fjov_pkg::PH_COMMA;
      else if (c == CH_RBRACE) phase = fjov_pkg::PH_END;
      else begin
        void'(raise(fjov_pkg::ERR_COMMA));
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void number_step(logic [7:0] c, inout byte_tag_t t);
      fjov_pkg::num_phase_t nx;
      bit                   ok;
      nx = num_advance(num_st, c);
      if (nx != fjov_pkg::NS_STOP) begin
        num_st = nx;
        if (num_accepting(nx)) got_prefix = 1'b1;
        t.cls = (nx == fjov_pkg::NS_START) ? fjov_pkg::CLS_STRUCT : fjov_pkg::CLS_NUM;
      end else if (num_accepting(num_st)) begin
        ok          = close_value(c);
        t.value_end = ok;
        t.cls       = ok ? fjov_pkg::CLS_STRUCT : fjov_pkg::CLS_IGNORED;
      end else begin
        t.cls = raise(got_prefix ? fjov_pkg::ERR_COMMA : fjov_pkg::ERR_NUMBER);
      end
    endfunction

    function byte_tag_t classify(logic [7:0] c);
      byte_tag_t t;
      t.cls       = fjov_pkg::CLS_STRUCT;
      t.key_end   = 1'b0;
      t.value_end = 1'b0;
      t.text_done = 1'b0;
      t.accepted  = 1'b0;
      t.err       = fjov_pkg::ERR_NONE;
      case (phase)
        fjov_pkg::PH_OPEN: begin
          if (c == CH_NUL) t.cls = raise(fjov_pkg::ERR_EMPTY);
          else if (c == CH_LBRACE) phase = fjov_pkg::PH_TOP;
          else t.cls = raise(fjov_pkg::ERR_NO_BRACE);
        end
        fjov_pkg::PH_TOP, fjov_pkg::PH_COMMA: begin
          if (c == CH_RBRACE) phase = fjov_pkg::PH_END;
          else if (c == CH_NUL) t.cls = raise(fjov_pkg::ERR_BAD_END);
          else if (c == CH_QUOTE) begin
            phase = fjov_pkg::PH_KEY;
            t.cls = fjov_pkg::CLS_KEY;
          end else if (c == CH_SPACE) begin
            // spaces after a comma keep the comma phase, so a brace may follow
            if (phase == fjov_pkg::PH_TOP) phase = fjov_pkg::PH_KEYWAIT;
          end else t.cls = raise(fjov_pkg::ERR_KEY);
        end
        fjov_pkg::PH_KEYWAIT: begin
          if (c == CH_QUOTE) begin
            phase = fjov_pkg::PH_KEY;
            t.cls = fjov_pkg::CLS_KEY;
          end else if (c != CH_SPACE) t.cls = raise(fjov_pkg::ERR_KEY);
        end
        fjov_pkg::PH_KEY: begin
          if (c == CH_NUL) t.cls = raise(fjov_pkg::ERR_KEY_QUOTE);
          else begin
            t.cls = fjov_pkg::CLS_KEY;
            if (c == CH_QUOTE) begin
              t.key_end = 1'b1;
              phase     = fjov_pkg::PH_COLON;
            end
          end
        end
        fjov_pkg::PH_COLON: begin
          if (c == CH_COLON) phase = fjov_pkg::PH_VALWAIT;
          else if (c != CH_SPACE) t.cls = raise(fjov_pkg::ERR_COLON);
        end
        fjov_pkg::PH_VALWAIT: begin
          if (c == CH_SPACE) ;
          else if (c == CH_NUL || c == CH_RBRACE) t.cls = raise(fjov_pkg::ERR_VALUE);
          else if (c == CH_QUOTE) begin
            phase = fjov_pkg::PH_STR;
            t.cls = fjov_pkg::CLS_STR;
          end else begin
            phase      = fjov_pkg::PH_NUM;
            num_st     = fjov_pkg::NS_START;
            got_prefix = 1'b0;
            number_step(c, t);
          end
        end
        fjov_pkg::PH_STR: begin
          if (c == CH_NUL) t.cls = raise(fjov_pkg::ERR_STR_QUOTE);
          else begin
            t.cls = fjov_pkg::CLS_STR;
            if (c == CH_QUOTE) begin
              t.value_end = 1'b1;
              phase       = fjov_pkg::PH_AFTERVAL;
            end
          end
        end
        fjov_pkg::PH_NUM: number_step(c, t);
        fjov_pkg::PH_AFTERVAL:
          t.cls = close_value(c) ? fjov_pkg::CLS_STRUCT : fjov_pkg::CLS_IGNORED;
        fjov_pkg::PH_END: if (c != CH_NUL) t.cls = raise(fjov_pkg::ERR_BAD_END);
        fjov_pkg::PH_ERR: t.cls = fjov_pkg::CLS_IGNORED;
        default: t.cls = raise(fjov_pkg::ERR_BAD_END);
      endcase
      // end byte reports the verdict and rearms for the next text
      if (c == CH_NUL) begin
        t.cls       = fjov_pkg::CLS_STRUCT;
        t.text_done = 1'b1;
        t.err       = first_err;
        t.accepted  = (first_err == fjov_pkg::ERR_NONE);
        restart();
      end
      return t;
    endfunction

    function void note_byte(logic [7:0] c);
      expected_tags.push_back(classify(c));
    endfunction

    function void check_tag(byte_tag_t seen);
      byte_tag_t want;
      if (expected_tags.size() == 0) begin
        $error("unexpected result transfer, class %0d", seen.cls);
        failures++;
        return;
      end
      want = expected_tags.pop_front();
      if (seen.cls !== want.cls) begin
        $error("byte_class expected %0d actual %0d", want.cls, seen.cls);
        failures++;
      end
      if (seen.key_end !== want.key_end) begin
        $error("key_end expected %0d actual %0d", want.key_end, seen.key_end);
        failures++;
      end
      if (seen.value_end !== want.value_end) begin
        $error("value_end expected %0d actual %0d", want.value_end, seen.value_end);
        failures++;
      end
      if (seen.text_done !== want.text_done) begin
        $error("text_done expected %0d actual %0d", want.text_done, seen.text_done);
        failures++;
      end
      if (seen.accepted !== want.accepted) begin
        $error("accepted expected %0d actual %0d", want.accepted, seen.accepted);
        failures++;
      end
      if (seen.err !== want.err) begin
        $error("error_kind expected %0d actual %0d", want.err, seen.err);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  fjov_text_if   text_ch ();
  fjov_result_if result_ch ();

  flat_json_object_validator dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  json_tag_board tags;
  logic [7:0]    text_q[$];
  int            burst_left = 0;
  int            bytes_sent = 0;
  int            cycle_count = 0;
  int            stall_tick = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("flat_json_object_validator: mismatch");
      $finish;
    end
  end

  // Receiver backpressure: rotates through free-running, periodic, random
  // and long-stall stretches
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 80) % 4)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= (stall_tick % 5) < 3;
      2: result_ch.ready <= 1'($urandom_range(0, 1));
      default: result_ch.ready <= (stall_tick % 16) >= 10;
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      byte_tag_t seen;
      seen.cls       = fjov_pkg::byte_class_t'(result_ch.byte_class);
      seen.key_end   = result_ch.key_end;
      seen.value_end = result_ch.value_end;
      seen.text_done = result_ch.text_done;
      seen.accepted  = result_ch.accepted;
      seen.err       = fjov_pkg::err_t'(result_ch.error_kind);
      tags.check_tag(seen);
    end
  end

  // Sends the queued text in bursts with random gaps
  task automatic send_queue();
    int gap;
    foreach (text_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          text_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      text_ch.valid     <= 1'b1;
      text_ch.text_byte <= text_q[i];
      do @(posedge clk); while (!text_ch.ready);
      tags.note_byte(text_q[i]);
      @(negedge clk);
      burst_left--;
      bytes_sent++;
    end
    text_q.delete();
  endtask

  // Holds the sender off until every owed tag has come back
  task automatic wait_drained();
    text_ch.valid <= 1'b0;
    do @(negedge clk); while (tags.pending() != 0);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    add_str(s);
    text_q.push_back(CH_NUL);
    send_queue();
  endtask

  function automatic void add_mixcase(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      text_q.push_back(c);
    end
  endfunction

  function automatic void add_digits(int lo, int hi, bit hex);
    string hexset;
    hexset = "0123456789abcdefABCDEF";
    repeat ($urandom_range(lo, hi)) begin
      if (hex) text_q.push_back(hexset[$urandom_range(0, 21)]);
      else text_q.push_back(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_spaces();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
  endfunction

  // Quoted key or string value with arbitrary content bytes
  function automatic void add_quoted();
    logic [7:0] c;
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(1, 255));
      if (c == CH_QUOTE) c = "q";
      text_q.push_back(c);
    end
    text_q.push_back(CH_QUOTE);
  endfunction

  function automatic void add_number();
    int ws;
    int k;
    string wordset;
    wordset = "aZ9_x0";
    if ($urandom_range(0, 7) == 0) begin
      ws = $urandom_range(9, 14);
      text_q.push_back((ws == 14) ? CH_SPACE : 8'(ws));
      if ($urandom_range(0, 1)) text_q.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 2) == 0) text_q.push_back($urandom_range(0, 1) ? "-" : "+");
    case ($urandom_range(0, 5))
      0: add_digits(1, 3, 1'b0);
      1: begin
        add_digits(1, 3, 1'b0);
        if ($urandom_range(0, 1)) begin
          text_q.push_back(".");
          add_digits(0, 2, 1'b0);
        end
        if ($urandom_range(0, 1)) begin
          add_mixcase("e");
          if ($urandom_range(0, 1)) text_q.push_back($urandom_range(0, 1) ? "-" : "+");
          add_digits(1, 2, 1'b0);
        end
      end
      2: begin
        text_q.push_back("0");
        add_mixcase("x");
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(".");
          add_digits(1, 2, 1'b1);
        end else begin
          add_digits(1, 3, 1'b1);
          if ($urandom_range(0, 1)) begin
            text_q.push_back(".");
            add_digits(0, 2, 1'b1);
          end
        end
        if ($urandom_range(0, 1)) begin
          add_mixcase("p");
          if ($urandom_range(0, 1)) text_q.push_back($urandom_range(0, 1) ? "-" : "+");
          add_digits(1, 2, 1'b0);
        end
      end
      3: add_mixcase($urandom_range(0, 1) ? "inf" : "infinity");
      4: begin
        add_mixcase("nan");
        if ($urandom_range(0, 1)) begin
          text_q.push_back("(");
          repeat ($urandom_range(0, 3)) begin
            k = $urandom_range(0, 5);
            add_mixcase(wordset.substr(k, k));
          end
          text_q.push_back(")");
        end
      end
      default: begin
        text_q.push_back(".");
        add_digits(1, 2, 1'b0);
        if ($urandom_range(0, 1)) begin
          add_mixcase("e");
          add_digits(1, 2, 1'b0);
        end
      end
    endcase
  endfunction

  // Well-formed object with random pairs and spacing
  function automatic void add_object();
    int pairs;
    pairs = $urandom_range(0, 4);
    text_q.push_back(CH_LBRACE);
    if (pairs > 0 || $urandom_range(0, 7) == 0) add_spaces();
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) begin
        text_q.push_back(CH_COMMA);
        add_spaces();
      end
      add_quoted();
      add_spaces();
      text_q.push_back(CH_COLON);
      add_spaces();
      if ($urandom_range(0, 2) == 0) add_quoted();
      else add_number();
      add_spaces();
    end
    if (pairs > 0 && $urandom_range(0, 4) == 0) begin
      text_q.push_back(CH_COMMA);
      add_spaces();
    end
    text_q.push_back(CH_RBRACE);
  endfunction

  // Damages one spot of the text under construction
  function automatic void corrupt_text();
    int idx;
    if (text_q.size() == 0) return;
    idx = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 4))
      0: text_q[idx] = 8'($urandom_range(1, 255));
      1: text_q.delete(idx);
      2: text_q.insert(idx, 8'($urandom_range(1, 255)));
      3: while (text_q.size() > idx) void'(text_q.pop_back());
      default: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  task automatic run_directed();
    send_text("");
    send_text("{}");
    send_text("[]");
    send_text("{}}");
    send_text("{\"a\":1,");
    send_text("{ }");
    send_text("{ \"k\" : \"v\" , \"n\":-12.5e+3 }");
    send_text("{\"k\":\"v\", }");
    send_text("{\"a\"x}");
    send_text("{\"a\":}");
    send_text("{\"a\":\"xy");
    send_text("{\"ab");
    send_text("{\"a\":\t \"s\"}");
    send_text("{\"a\":1e,}");
    send_text("{\"a\":-,}");
    send_text("{\"a\":0x.fp+2,\"b\":nan(x_9),\"c\":NaN,\"d\":inf,\"e\":.5}");
    send_text("{\"a\":infi}");
    send_text("{\"a\":1");
    send_text("x{\"a\"");
    send_text("{ x");
    // every whitespace kind inside a number, then hex and infinity
    add_str("{\"w\":");
    for (int w = 9; w <= 13; w++) text_q.push_back(8'(w));
    send_text(" 7,\"b\":0X1.8P-3,\"c\":-INFinity}");
    // high bytes: content inside quotes, invalid as structure
    add_str("{\"");
    text_q.push_back(8'hc8);
    add_str("\":\"");
    text_q.push_back(8'hff);
    send_text("\"}");
    add_str("{");
    text_q.push_back(8'h80);
    send_text("");
  endtask

  initial begin
    tags                = new();
    rst                 = 1'b1;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = 8'h00;
    result_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    wait_drained();

    // Random texts: mostly well-formed objects, some damaged, some raw noise
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_object();
        if ($urandom_range(0, 9) < 3) corrupt_text();
      end
      text_q.push_back(CH_NUL);
      send_queue();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tags.failures == 0) $display("flat_json_object_validator: match");
    else $display("flat_json_object_validator: mismatch");
    $finish;
  end

endmodule
